>>> sv/b62e_pkg.sv
package b62e_pkg;

	localparam int NUM_W      = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 6;
	localparam int QUO_W      = 27;
	localparam int ALPHA_SIZE = 62;
	localparam int IN_DATA_W  = 56;

	// floor(2^37 / 62): quotient estimate is exact or one low
	localparam logic [NUM_W-1:0] RECIP = 32'd2216757314;
	localparam int RECIP_SHIFT = 37;
	localparam logic [6:0] RADIX = 7'd62;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;
	localparam logic [CHAR_W-1:0] LEARN_CHAR = 8'd0;

	localparam int CODE_CHARS   = 3;
	localparam int LEARN_DIGITS = (CODE_CHARS < 3) ? CODE_CHARS : 3;

	localparam logic CMD_LEARN  = 1'b0;
	localparam logic CMD_ENCODE = 1'b1;

	localparam logic [1:0] CODE_SEL_FIRST  = 2'd0;
	localparam logic [1:0] CODE_SEL_SECOND = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_CORR,
		ST_LRD,
		ST_LWR,
		ST_LOUT,
		ST_MINUS,
		ST_ERD,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic corr;
		logic lrd;
		logic lwr;
		logic erd;
		logic emit_learn;
		logic emit_minus;
		logic emit_char;
	} dp_cmd_t;

	typedef struct packed {
		logic is_encode;
		logic neg;
		logic in_skip;
		logic quo_zero;
		logic nd_last;
		logic val_zero;
		logic k_last;
		logic nd_zero;
		logic out_free;
	} dp_stat_t;

	function automatic logic [CHAR_W-1:0] std_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dd;
		dd = {2'b00, d};
		if (d < 6'd10)
			return 8'd48 + dd;
		else if (d < 6'd36)
			return 8'd55 + dd;
		else
			return 8'd61 + dd;
	endfunction

endpackage

>>> sv/base62_learned_alphabet_encoder_core.sv
// Base-62 encoder with a learnable 62-entry alphabet.
// Input stream s_axis: one request per item. tuser is the command (0 learn,
// 1 encode); tdata holds number[31:0], code_first, code_second, code_third.
// Output stream m_axis: tdata is one character, tlast marks the final
// character of a request, tuser is the learn conflict flag.
// A learn request returns one item (character 0, tlast 1, conflict flag).
// An encode request returns '-' for a negative number, then the base-62
// digits most significant first, mapped through the alphabet.
// Steps: each digit passes through one 32x32 reciprocal multiply and a
// correction step. Learn adds an alphabet read and a write per digit;
// encode adds a step for the minus sign and, per emitted character, an
// alphabet read and an output load.
// One request is in work at a time; s_axis_tready is high only while idle.
// A registered output stage holds the last result, so a new request is
// taken while it waits. When the receiver stalls, the core holds the
// current character and waits. Reset restores the standard 0-9A-Za-z
// alphabet at once (learned bits cleared) and empties the output.
module base62_learned_alphabet_encoder_core #(
	parameter int MAX_DIGITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // number, code_first, code_second, code_third
	input  logic        s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // character
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // conflict
);

	b62e_pkg::dp_cmd_t  dp_cmd;
	b62e_pkg::dp_stat_t dp_stat;

	b62e_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (dp_stat),
		.cmd           (dp_cmd)
	);

	b62e_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while busy");

	a_emit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.emit_learn, dp_cmd.emit_minus, dp_cmd.emit_char}))
		else $error("several output loads at once");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.emit_learn || dp_cmd.emit_minus || dp_cmd.emit_char) |-> dp_stat.out_free)
		else $error("output overwritten before taken");

	a_conflict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> !m_axis_tuser)
		else $error("conflict flag on a non-final item");
`endif

endmodule

>>> sv/b62e_datapath.sv
module b62e_datapath #(
	parameter int MAX_DIGITS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  b62e_pkg::dp_cmd_t   cmd,
	output b62e_pkg::dp_stat_t  stat,
	input  logic [55:0]         s_axis_tdata,  // number, code_first, code_second, code_third
	input  logic                s_axis_tuser,  // command
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,  // character
	output logic                m_axis_tlast,
	output logic                m_axis_tuser   // conflict
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	logic [31:0] in_number;
	logic [31:0] in_mag;

	logic        cmd_q;
	logic        neg_q;
	logic [7:0]  code_first_q;
	logic [7:0]  code_second_q;
	logic [7:0]  code_third_q;
	logic [31:0] val_q;
	logic [26:0] quo0_q;
	logic [5:0]  digit_q;
	logic [1:0]  k_q;
	logic        conf_q;
	logic [CNT_W-1:0] nd_q;
	logic [CNT_W-1:0] nd_m1;
	logic [5:0]  dbuf_q [MAX_DIGITS];

	logic [61:0] learned_q;
	logic [7:0]  alph_mem [0:61];
	logic [7:0]  rd_mem_q;
	logic        rd_lrn_q;
	logic [7:0]  rd_std_q;
	logic [5:0]  rd_addr;

	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        out_last_q;
	logic        out_conf_q;

	logic [63:0] prod;
	logic [32:0] q_sh6;
	logic [32:0] q_sh1;
	logic [32:0] q_x62;
	logic [32:0] rem_full;
	logic [6:0]  rem0;
	logic        corr_up;
	logic [5:0]  digit;
	logic [31:0] quo;
	logic [1:0]  code_idx;
	logic [7:0]  code_sel;
	logic        conflict;
	logic [7:0]  rd_char;

	assign in_number = s_axis_tdata[31:0];
	assign in_mag    = in_number[31] ? (32'd0 - in_number) : in_number;

	assign prod     = {32'd0, val_q} * {32'd0, b62e_pkg::RECIP};
	assign q_sh6    = {quo0_q, 6'b0};
	assign q_sh1    = {5'b0, quo0_q, 1'b0};
	assign q_x62    = q_sh6 - q_sh1;
	assign rem_full = {1'b0, val_q} - q_x62;
	assign rem0     = rem_full[6:0];
	assign corr_up  = (rem0 >= b62e_pkg::RADIX);
	assign digit    = corr_up ? 6'(rem0 - b62e_pkg::RADIX) : rem0[5:0];
	assign quo      = {5'd0, quo0_q} + {31'd0, corr_up};

	assign code_idx = 2'(b62e_pkg::LEARN_DIGITS - 1) - k_q;
	always_comb begin
		case (code_idx)
			b62e_pkg::CODE_SEL_FIRST:  code_sel = code_first_q;
			b62e_pkg::CODE_SEL_SECOND: code_sel = code_second_q;
			default:                   code_sel = code_third_q;
		endcase
	end

	assign conflict = rd_lrn_q && (rd_mem_q != code_sel);
	assign rd_char  = rd_lrn_q ? rd_mem_q : rd_std_q;
	assign nd_m1    = nd_q - CNT_W'(1);
	assign rd_addr  = cmd.erd ? dbuf_q[nd_m1[IDX_W-1:0]] : digit_q;

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q         <= s_axis_tuser;
			neg_q         <= in_number[31];
			code_first_q  <= s_axis_tdata[39:32];
			code_second_q <= s_axis_tdata[47:40];
			code_third_q  <= s_axis_tdata[55:48];
			val_q         <= in_mag;
		end else if (cmd.corr) begin
			val_q <= quo;
		end
		if (cmd.mul)
			quo0_q <= prod[63:b62e_pkg::RECIP_SHIFT];
		if (cmd.corr) begin
			digit_q <= digit;
			if (cmd_q == b62e_pkg::CMD_ENCODE)
				dbuf_q[nd_q[IDX_W-1:0]] <= digit;
		end
	end

	// alphabet store; unlearned entries read as the standard order
	always_ff @(posedge clk) begin
		if (cmd.lwr)
			alph_mem[digit_q] <= code_sel;
		if (cmd.lrd || cmd.erd) begin
			rd_mem_q <= alph_mem[rd_addr];
			rd_lrn_q <= learned_q[rd_addr];
			rd_std_q <= b62e_pkg::std_char(rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learned_q <= '0;
			nd_q      <= '0;
			k_q       <= '0;
			conf_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				nd_q   <= '0;
				k_q    <= '0;
				conf_q <= 1'b0;
			end else begin
				if (cmd.corr && (cmd_q == b62e_pkg::CMD_ENCODE))
					nd_q <= nd_q + CNT_W'(1);
				else if (cmd.erd)
					nd_q <= nd_m1;
				if (cmd.lwr) begin
					learned_q[digit_q] <= 1'b1;
					k_q                <= k_q + 2'd1;
					if (conflict)
						conf_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_learn || cmd.emit_minus || cmd.emit_char) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_learn) begin
			out_char_q <= b62e_pkg::LEARN_CHAR;
			out_last_q <= 1'b1;
			out_conf_q <= conf_q;
		end else if (cmd.emit_minus) begin
			out_char_q <= b62e_pkg::MINUS_CHAR;
			out_last_q <= 1'b0;
			out_conf_q <= 1'b0;
		end else if (cmd.emit_char) begin
			out_char_q <= rd_char;
			out_last_q <= (nd_q == '0);
			out_conf_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_conf_q;

	assign stat.is_encode = (cmd_q == b62e_pkg::CMD_ENCODE);
	assign stat.neg       = neg_q;
	assign stat.in_skip   = (s_axis_tuser == b62e_pkg::CMD_LEARN)
		&& (in_number[31] || (in_number == 32'd0));
	assign stat.quo_zero  = (quo == 32'd0);
	assign stat.nd_last   = (nd_q == CNT_W'(MAX_DIGITS - 1));
	assign stat.val_zero  = (val_q == 32'd0);
	assign stat.k_last    = (k_q == 2'(b62e_pkg::LEARN_DIGITS - 1));
	assign stat.nd_zero   = (nd_q == '0);
	assign stat.out_free  = !out_valid_q || m_axis_tready;

endmodule

>>> sv/b62e_ctrl.sv
module b62e_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  b62e_pkg::dp_stat_t stat,
	output b62e_pkg::dp_cmd_t  cmd
);

	b62e_pkg::state_t state_q;
	b62e_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b62e_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			b62e_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = stat.in_skip ? b62e_pkg::ST_LOUT : b62e_pkg::ST_MUL;
				end
			end
			b62e_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = b62e_pkg::ST_CORR;
			end
			b62e_pkg::ST_CORR: begin
				cmd.corr = 1'b1;
				if (!stat.is_encode)
					state_d = b62e_pkg::ST_LRD;
				else if (stat.quo_zero || stat.nd_last)
					state_d = stat.neg ? b62e_pkg::ST_MINUS : b62e_pkg::ST_ERD;
				else
					state_d = b62e_pkg::ST_MUL;
			end
			b62e_pkg::ST_LRD: begin
				cmd.lrd = 1'b1;
				state_d = b62e_pkg::ST_LWR;
			end
			b62e_pkg::ST_LWR: begin
				cmd.lwr = 1'b1;
				state_d = (stat.val_zero || stat.k_last) ? b62e_pkg::ST_LOUT : b62e_pkg::ST_MUL;
			end
			b62e_pkg::ST_LOUT: begin
				if (stat.out_free) begin
					cmd.emit_learn = 1'b1;
					state_d        = b62e_pkg::ST_IDLE;
				end
			end
			b62e_pkg::ST_MINUS: begin
				if (stat.out_free) begin
					cmd.emit_minus = 1'b1;
					state_d        = b62e_pkg::ST_ERD;
				end
			end
			b62e_pkg::ST_ERD: begin
				cmd.erd = 1'b1;
				state_d = b62e_pkg::ST_EOUT;
			end
			b62e_pkg::ST_EOUT: begin
				if (stat.out_free) begin
					cmd.emit_char = 1'b1;
					state_d       = stat.nd_zero ? b62e_pkg::ST_IDLE : b62e_pkg::ST_ERD;
				end
			end
			default: begin
				state_d = b62e_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> sim/tb_base62_learned_alphabet_encoder_core.sv
`timescale 1ns / 1ps

module tb_base62_learned_alphabet_encoder_core;

	localparam int MAX_DIG     = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_DIR       = 21;
	localparam int N_RAND      = 150;
	localparam logic LRN       = b62e_pkg::CMD_LEARN;
	localparam logic ENC       = b62e_pkg::CMD_ENCODE;

	typedef struct packed {
		logic [b62e_pkg::CHAR_W-1:0] ch;
		logic                        last;
		logic                        conf;
	} out_char_t;

	// directed request; n_typed > 0 means the expected characters are given here
	typedef struct packed {
		logic                       cmd;
		logic [b62e_pkg::NUM_W-1:0] num;
		logic [7:0]                 c1;
		logic [7:0]                 c2;
		logic [7:0]                 c3;
		logic [3:0]                 n_typed;
		logic [55:0]                typed_chars;  // first character in the lowest byte
		logic                       typed_conf;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	string       std_order = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
	logic [7:0]  alpha_q [b62e_pkg::ALPHA_SIZE];
	logic        learned_q [b62e_pkg::ALPHA_SIZE];
	out_char_t   model_chars [$];
	out_char_t   pending_chars [$];
	dir_row_t    dir_rows [N_DIR];
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	int          fails = 0;
	int          cycles = 0;

	base62_learned_alphabet_encoder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result checker and receiver stalls
	always @(posedge clk) begin
		out_char_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected result: character %0d last %0b conflict %0b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
				fails++;
			end else begin
				e = pending_chars.pop_front();
				if (m_axis_tdata !== e.ch) begin
					$error("character: expected %0d, got %0d", e.ch, m_axis_tdata);
					fails++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, m_axis_tlast);
					fails++;
				end
				if (m_axis_tuser !== e.conf) begin
					$error("conflict: expected %0b, got %0b", e.conf, m_axis_tuser);
					fails++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic reset_alphabet();
		for (int i = 0; i < b62e_pkg::ALPHA_SIZE; i++) begin
			alpha_q[i] = std_order[i];
			learned_q[i] = 1'b0;
		end
	endtask

	// updates the alphabet and fills model_chars with the characters of one request
	task automatic compute_output_chars(input logic cmd,
			input logic [b62e_pkg::NUM_W-1:0] num,
			input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
		logic [7:0]                 codes [3];
		logic [b62e_pkg::NUM_W-1:0] v;
		logic [5:0]                 d;
		logic [5:0]                 digs [MAX_DIG];
		logic                       conf;
		int                         nd;
		codes[0] = c1;
		codes[1] = c2;
		codes[2] = c3;
		model_chars.delete();
		conf = 1'b0;
		if (cmd == b62e_pkg::CMD_LEARN) begin
			if (!num[31]) begin
				v = num;
				for (int k = 0; k < b62e_pkg::LEARN_DIGITS && v != 0; k++) begin
					d = 6'(v % 62);
					if (learned_q[d] && alpha_q[d] != codes[b62e_pkg::LEARN_DIGITS-1-k])
						conf = 1'b1;
					alpha_q[d] = codes[b62e_pkg::LEARN_DIGITS-1-k];
					learned_q[d] = 1'b1;
					v = v / 62;
				end
			end
			model_chars.push_back('{b62e_pkg::LEARN_CHAR, 1'b1, conf});
		end else begin
			v = num[31] ? (32'd0 - num) : num;
			if (v == 0) begin
				model_chars.push_back('{alpha_q[0], 1'b1, 1'b0});
			end else begin
				nd = 0;
				while (v != 0 && nd < MAX_DIG) begin
					digs[nd] = 6'(v % 62);
					v = v / 62;
					nd++;
				end
				if (num[31])
					model_chars.push_back('{b62e_pkg::MINUS_CHAR, 1'b0, 1'b0});
				for (int k = nd - 1; k >= 0; k--)
					model_chars.push_back('{alpha_q[digs[k]], k == 0, 1'b0});
			end
		end
	endtask

	task automatic send_request(input logic cmd, input logic [b62e_pkg::NUM_W-1:0] num,
			input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {c3, c2, c1, num};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [b62e_pkg::NUM_W-1:0] pick_number(input logic cmd);
		logic [b62e_pkg::NUM_W-1:0] n;
		case ($urandom_range(9))
			0, 1:    n = $urandom_range(0, 61);
			2, 3, 4: n = $urandom_range(0, 238327);
			5:       n = $urandom_range(238328, 32'h7FFF_FFFF);
			6:       n = 32'd0 - $urandom_range(1, 300000);
			7: begin
				case ($urandom_range(5))
					0: n = 32'h0000_0000;
					1: n = 32'h0000_0001;
					2: n = 32'h7FFF_FFFF;
					3: n = 32'h8000_0000;
					4: n = 32'h8000_0001;
					default: n = 32'hFFFF_FFFF;
				endcase
			end
			default: n = $urandom;
		endcase
		// learn requests mostly carry up to three digits
		if (cmd == b62e_pkg::CMD_LEARN && $urandom_range(3) != 0)
			n = $urandom_range(1, 238327);
		return n;
	endfunction

	function automatic logic [7:0] pick_code();
		if ($urandom_range(1) == 0)
			return 8'($urandom_range(8'h41, 8'h44));
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic                       cmd;
		logic [b62e_pkg::NUM_W-1:0] num;
		dir_row_t                   r;
		dir_rows = '{
			'{ENC, 32'd0,         8'h00, 8'h00, 8'h00, 4'd1, 56'h30,   1'b0},
			'{ENC, 32'd61,        8'h00, 8'h00, 8'h00, 4'd1, 56'h7A,   1'b0},
			'{ENC, 32'd62,        8'h00, 8'h00, 8'h00, 4'd2, 56'h3031, 1'b0},
			'{ENC, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 4'd2, 56'h312D, 1'b0},
			'{ENC, 32'h7FFF_FFFF, 8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{ENC, 32'h8000_0000, 8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{ENC, 32'h8000_0001, 8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{LRN, 32'd0,         8'h61, 8'h62, 8'h63, 4'd1, 56'h0,    1'b0},
			'{LRN, 32'hFFFF_FFFB, 8'h61, 8'h62, 8'h63, 4'd1, 56'h0,    1'b0},
			'{LRN, 32'd1,         8'h00, 8'h00, 8'h51, 4'd1, 56'h0,    1'b0},
			'{ENC, 32'd1,         8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{LRN, 32'd1,         8'hFF, 8'hFF, 8'h51, 4'd0, 56'h0,    1'b0},
			'{LRN, 32'd1,         8'h00, 8'h00, 8'h52, 4'd0, 56'h0,    1'b0},
			'{LRN, 32'd19413,     8'hFF, 8'h00, 8'h80, 4'd0, 56'h0,    1'b0},
			'{LRN, 32'd480563,    8'h11, 8'h55, 8'hAA, 4'd0, 56'h0,    1'b0},
			'{ENC, 32'h7FFF_FFFF, 8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{LRN, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 56'h0,    1'b0},
			'{ENC, 32'h8000_0000, 8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{ENC, 32'd3844,      8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{LRN, 32'd61,        8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0},
			'{ENC, 32'd61,        8'h00, 8'h00, 8'h00, 4'd0, 56'h0,    1'b0}
		};
		reset_alphabet();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			r = dir_rows[i];
			send_request(r.cmd, r.num, r.c1, r.c2, r.c3);
			compute_output_chars(r.cmd, r.num, r.c1, r.c2, r.c3);
			if (r.n_typed != 0) begin
				for (int k = 0; k < r.n_typed; k++)
					pending_chars.push_back('{r.typed_chars[8*k +: 8], k == r.n_typed - 1,
						r.typed_conf});
			end else begin
				foreach (model_chars[k])
					pending_chars.push_back(model_chars[k]);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 65 : 0;
			sink_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 7 : 0;
			for (int i = 0; i < N_RAND; i++) begin
				cmd = ($urandom_range(99) < 35) ? b62e_pkg::CMD_LEARN : b62e_pkg::CMD_ENCODE;
				num = pick_number(cmd);
				r.c1 = pick_code();
				r.c2 = pick_code();
				r.c3 = pick_code();
				send_request(cmd, num, r.c1, r.c2, r.c3);
				compute_output_chars(cmd, num, r.c1, r.c2, r.c3);
				foreach (model_chars[k])
					pending_chars.push_back(model_chars[k]);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0 && pending_chars.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
